@@ hdl/bounded_probe_hash_dedup_core_assert.svh @@
// Assertion macros shared by the checker of the dedup core.
// Depends on nothing; the includer supplies clock, reset and expressions.
`ifndef BOUNDED_PROBE_HASH_DEDUP_CORE_ASSERT_SVH
`define BOUNDED_PROBE_HASH_DEDUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPHD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dedup core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPHD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dedup core check failed");

`endif

@@ hdl/bphd_pkg.sv @@
// Types and constants of the bounded-probe hash dedup core.
// Used by every module of the core but bphd_table; depends on nothing.
package bphd_pkg;

    localparam logic [31:0] EMPTY_KEY = 32'hffff_ffff;
    localparam logic [31:0] MIX_MUL1  = 32'h7feb_352d;
    localparam logic [31:0] MIX_MUL2  = 32'h846c_a68b;
    localparam int          MIX_SH_A  = 16;
    localparam int          MIX_SH_B  = 15;

    localparam int PROBE_CAP = 1024;
    localparam int USED_W    = 11;
    localparam int PROBE_W   = 10;
    localparam int CAP_W     = 4;
    localparam int LG_W      = 5;
    localparam int CFG_W     = 11;

    localparam logic CFG_CAPACITY_LOG2 = 1'b0;
    localparam logic CFG_MAX_PROBE     = 1'b1;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        OUT_INSERTED  = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_OVERFLOW  = 2'd2,
        OUT_CLEARED   = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_CLR_OUT,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SLOT,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic              upd;
        logic              clr;
        outcome_t          outcome;
        logic [USED_W-1:0] used;
    } stats_cmd_t;

endpackage

@@ hdl/bounded_probe_hash_dedup_core.sv @@
// Channel   Direction  Contents
// s_        in         tuser: cmd; tdata: key
// m_        out        tuser: outcome; tdata: probes_used and running totals
// cfg_      in         register writes, index 0 capacity_log2, 1 max_probe_count
//
// An insert's result is loaded after the mixer states ST_MUL1 and ST_MUL2, the read of the first
// slot and one compare per slot read (at least one slot is read); the last compare waits while
// an earlier result is unread. The next item is then accepted in the idle state.
// A clear, and reset, sweep every slot of the memory once, 2**floor(log2(TABLE_DEPTH)) slots,
// while s_tready is low. The clear result follows the sweep.
// A result waits in the output register; a later result stalls until it is taken.
module bounded_probe_hash_dedup_core
    import bphd_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [31:0] key
    input  logic             s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    // [10:0] probes_used, [42:11] inserted_total, [74:43] duplicate_total,
    // [106:75] overflow_total, [117:107] max_probe_seen, [119:118] zero
    output logic [119:0]     m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] outcome
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int          TOP_LG  = $clog2(TABLE_DEPTH + 1) - 1;
    localparam logic [LG_W-1:0] TOP_LG_V = LG_W'(TOP_LG);

    state_t              state_reg, state_next;
    logic [31:0]         key_reg, key_next;
    logic [TOP_LG-1:0]   slot_reg, slot_next;
    logic [TOP_LG-1:0]   sweep_reg, sweep_next;
    logic [PROBE_W-1:0]  probe_reg, probe_next;
    logic                clr_pend_reg, clr_pend_next;
    logic                m_tvalid_reg, m_tvalid_next;
    outcome_t            out_kind_reg, out_kind_next;
    logic [USED_W-1:0]   out_used_reg, out_used_next;
    logic [CAP_W-1:0]    cap_lg_reg;
    logic [USED_W-1:0]   probe_limit_reg;

    logic [LG_W-1:0]     lg_eff;
    logic [TOP_LG-1:0]   mask;
    logic [USED_W-1:0]   bound;
    logic [31:0]         hash;
    logic [TOP_LG-1:0]   slot_first;
    logic [TOP_LG-1:0]   slot_inc;
    logic                out_free;
    logic                resolved;
    outcome_t            res_kind;
    logic [USED_W-1:0]   res_used;

    logic                mem_we;
    logic [TOP_LG-1:0]   mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [TOP_LG-1:0]   mem_raddr;
    logic [31:0]         mem_rdata;
    stats_cmd_t          stats_cmd;

    logic [31:0]         ins_total, dup_total, ovf_total;
    logic [USED_W-1:0]   max_seen;

    bphd_mix u_mix (
        .aclk (aclk),
        .key  (key_reg),
        .hash (hash)
    );

    bphd_table #(
        .ADDR_W (TOP_LG)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    bphd_stats u_stats (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (stats_cmd),
        .inserted_total  (ins_total),
        .duplicate_total (dup_total),
        .overflow_total  (ovf_total),
        .max_probe_seen  (max_seen)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_lg_reg      <= CAP_W'(10);
            probe_limit_reg <= USED_W'(64);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CAPACITY_LOG2: cap_lg_reg      <= cfg_wr_data[CAP_W-1:0];
                CFG_MAX_PROBE:     probe_limit_reg <= cfg_wr_data[USED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capacity in use is clamped to [1, TOP_LG]; the probe bound to PROBE_CAP.
    always_comb begin
        if (cap_lg_reg == '0) begin
            lg_eff = LG_W'(1);
        end else if ({1'b0, cap_lg_reg} > TOP_LG_V) begin
            lg_eff = TOP_LG_V;
        end else begin
            lg_eff = {1'b0, cap_lg_reg};
        end
        for (int i = 0; i < TOP_LG; i++) begin
            mask[i] = (LG_W'(i) < lg_eff);
        end
        if (probe_limit_reg > USED_W'(PROBE_CAP)) begin
            bound = USED_W'(PROBE_CAP);
        end else begin
            bound = probe_limit_reg;
        end
    end

    assign slot_first = hash[TOP_LG-1:0] & mask;
    assign slot_inc   = (slot_reg + 1'b1) & mask;
    assign out_free   = !m_tvalid_reg || m_tready;

    // Outcome of the probe whose slot was read last.
    always_comb begin
        resolved = 1'b1;
        res_kind = OUT_OVERFLOW;
        res_used = USED_W'(probe_reg) + USED_W'(1);
        if (bound == '0) begin
            res_kind = OUT_OVERFLOW;
            res_used = USED_W'(1);
        end else if (mem_rdata == EMPTY_KEY) begin
            res_kind = OUT_INSERTED;
        end else if (mem_rdata == key_reg) begin
            res_kind = OUT_DUPLICATE;
        end else if (USED_W'(probe_reg) + USED_W'(1) == bound) begin
            res_kind = OUT_OVERFLOW;
            res_used = USED_W'(probe_reg) + USED_W'(2);
        end else begin
            resolved = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        sweep_next    = sweep_reg;
        probe_next    = probe_reg;
        clr_pend_next = clr_pend_reg;
        out_kind_next = out_kind_reg;
        out_used_next = out_used_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        s_tready      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = slot_reg;
        mem_wdata     = key_reg;
        mem_re        = 1'b0;
        mem_raddr     = slot_reg;
        stats_cmd     = '0;
        case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = EMPTY_KEY;
                if (sweep_reg == '1) begin
                    state_next = clr_pend_reg ? ST_CLR_OUT : ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_CLR_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_kind_next = OUT_CLEARED;
                    out_used_next = '0;
                    stats_cmd.clr = 1'b1;
                    clr_pend_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    key_next = s_tdata;
                    if (s_tuser == CMD_CLEAR) begin
                        sweep_next    = '0;
                        clr_pend_next = 1'b1;
                        state_next    = ST_SWEEP;
                    end else begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SLOT;
            ST_SLOT: begin
                mem_re     = 1'b1;
                mem_raddr  = slot_first;
                slot_next  = slot_first;
                probe_next = '0;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (resolved) begin
                    // Hold the read data and wait here while the previous result is unread.
                    if (out_free) begin
                        m_tvalid_next     = 1'b1;
                        out_kind_next     = res_kind;
                        out_used_next     = res_used;
                        stats_cmd.upd     = 1'b1;
                        stats_cmd.outcome = res_kind;
                        stats_cmd.used    = res_used;
                        mem_we            = (res_kind == OUT_INSERTED);
                        state_next        = ST_IDLE;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_inc;
                    slot_next  = slot_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            clr_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            clr_pend_reg <= clr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        probe_reg    <= probe_next;
        out_kind_reg <= out_kind_next;
        out_used_reg <= out_used_next;
    end

    // Totals change only when a result is loaded, so they are shown straight from the counters.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, max_seen, ovf_total, dup_total, ins_total, out_used_reg};

endmodule

@@ hdl/bphd_mix.sv @@
// Two-stage shift-xor-multiply key finalizer of the dedup core.
// Depends on bphd_pkg for the mixing constants.
module bphd_mix
    import bphd_pkg::*;
(
    input  logic        aclk,
    input  logic [31:0] key,
    output logic [31:0] hash
);

    logic [31:0] prod1_reg;
    logic [31:0] prod2_reg;
    logic [31:0] x1;
    logic [31:0] x2;

    assign x1 = key ^ (key >> MIX_SH_A);
    assign x2 = prod1_reg ^ (prod1_reg >> MIX_SH_B);

    // Free-running stages: the key is held through both multiply states before the hash is used.
    always_ff @(posedge aclk) begin
        prod1_reg <= x1 * MIX_MUL1;
        prod2_reg <= x2 * MIX_MUL2;
    end

    assign hash = prod2_reg ^ (prod2_reg >> MIX_SH_A);

endmodule

@@ hdl/bphd_table.sv @@
// Slot key memory of the dedup core: one write port, one registered read port.
// Depends on nothing but its address width parameter.
module bphd_table #(
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bphd_stats.sv @@
// Saturating outcome counters and probe maximum of the dedup core.
// Depends on bphd_pkg for the update struct and outcome codes.
module bphd_stats
    import bphd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stats_cmd_t        cmd,
    output logic [31:0]       inserted_total,
    output logic [31:0]       duplicate_total,
    output logic [31:0]       overflow_total,
    output logic [USED_W-1:0] max_probe_seen
);

    logic [31:0]       ins_reg, ins_next;
    logic [31:0]       dup_reg, dup_next;
    logic [31:0]       ovf_reg, ovf_next;
    logic [USED_W-1:0] max_reg, max_next;

    always_comb begin
        ins_next = ins_reg;
        dup_next = dup_reg;
        ovf_next = ovf_reg;
        max_next = max_reg;
        if (cmd.clr) begin
            ins_next = '0;
            dup_next = '0;
            ovf_next = '0;
            max_next = '0;
        end else if (cmd.upd) begin
            if (cmd.used > max_reg) begin
                max_next = cmd.used;
            end
            case (cmd.outcome)
                OUT_INSERTED: begin
                    if (ins_reg != '1) ins_next = ins_reg + 32'd1;
                end
                OUT_DUPLICATE: begin
                    if (dup_reg != '1) dup_next = dup_reg + 32'd1;
                end
                OUT_OVERFLOW: begin
                    if (ovf_reg != '1) ovf_next = ovf_reg + 32'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_reg <= '0;
            dup_reg <= '0;
            ovf_reg <= '0;
            max_reg <= '0;
        end else begin
            ins_reg <= ins_next;
            dup_reg <= dup_next;
            ovf_reg <= ovf_next;
            max_reg <= max_next;
        end
    end

    assign inserted_total  = ins_reg;
    assign duplicate_total = dup_reg;
    assign overflow_total  = ovf_reg;
    assign max_probe_seen  = max_reg;

endmodule

@@ hdl/bphd_checker.sv @@
// Port-level checks of the dedup core and the bind that attaches them.
// Depends on bphd_pkg and bounded_probe_hash_dedup_core_assert.svh.
`include "bounded_probe_hash_dedup_core_assert.svh"

module bphd_checker
    import bphd_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser
);

    logic is_clear;
    logic is_probe;

    assign is_clear = m_tvalid && (m_tuser == OUT_CLEARED);
    assign is_probe = m_tvalid && (m_tuser != OUT_CLEARED);

    // A clear result reports zero probes and zeroed totals.
    `BPHD_ASSERT_IMP(a_clear_zero, aclk, aresetn, is_clear, m_tdata == '0)
    // Every insert examines at least one slot or reports the bound plus one.
    `BPHD_ASSERT_IMP(a_probe_nonzero, aclk, aresetn, is_probe, m_tdata[10:0] != 11'd0)
    // The running maximum covers the probe count of the result it comes with.
    `BPHD_ASSERT_IMP(a_max_covers, aclk, aresetn, is_probe, m_tdata[10:0] <= m_tdata[117:107])
    // A stalled result stays on the port unchanged.
    `BPHD_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind bounded_probe_hash_dedup_core bphd_checker u_bphd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb.sv @@
// Self-checking testbench for bounded_probe_hash_dedup_core: directed and random inserts and
// clears, predicted by a behavioral hash set. Depends on bphd_pkg and the core's RTL only.
`timescale 1ns / 1ps

module tb;
    import bphd_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_LG      = $clog2(TABLE_DEPTH);
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_LEN    = 500;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] key;
    } req_t;

    typedef struct {
        outcome_t          outcome;
        logic [USED_W-1:0] used;
        logic [31:0]       ins;
        logic [31:0]       dup;
        logic [31:0]       ovf;
        logic [USED_W-1:0] peak;
    } res_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata     = '0;   // [31:0] key
    logic               s_tuser     = 1'b0; // [0] cmd
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    // [10:0] probes_used, [42:11] inserted_total, [74:43] duplicate_total,
    // [106:75] overflow_total, [117:107] max_probe_seen, [119:118] zero
    logic [119:0]       m_tdata;
    logic [1:0]         m_tuser;    // [1:0] outcome
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_index   = CFG_CAPACITY_LOG2;
    logic [CFG_W-1:0]   cfg_wr_data = '0;

    // Behavioral copy of the hash set and its settings.
    logic [31:0]        stored_keys [TABLE_DEPTH];
    logic [31:0]        ins_tot, dup_tot, ovf_tot;
    logic [USED_W-1:0]  peak_used;
    logic [3:0]         cap_shadow   = 4'd10;
    logic [CFG_W-1:0]   bound_shadow = 11'd64;

    req_t               pending [$];
    res_t               result_q [$];
    int unsigned        gap_left   = 0;
    int unsigned        stall_left = 0;
    bit                 held_off   = 1'b0;
    bit                 quiet      = 1'b0;
    int unsigned        in_count   = 0;
    int unsigned        errors     = 0;
    int unsigned        cycles     = 0;

    bounded_probe_hash_dedup_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] mix32(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x ^ (x >> MIX_SH_A);
        x = x * MIX_MUL1;
        x = x ^ (x >> MIX_SH_B);
        x = x * MIX_MUL2;
        x = x ^ (x >> MIX_SH_A);
        return x;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

    // Mostly short gaps, with an occasional long one; none while quiet is set.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_set();
        for (int i = 0; i < TABLE_DEPTH; i++) stored_keys[i] = EMPTY_KEY;
        ins_tot   = '0;
        dup_tot   = '0;
        ovf_tot   = '0;
        peak_used = '0;
    endtask

    task automatic dedup_predict(input req_t rq, output res_t r);
        int unsigned lg, bound, probe;
        logic [31:0] mask, slot;
        outcome_t    oc;
        if (rq.cmd == CMD_CLEAR) begin
            clear_set();
            r.outcome = OUT_CLEARED;
            r.used    = '0;
        end else begin
            lg = cap_shadow;
            if (lg < 1) lg = 1;
            if (lg > TBL_LG) lg = TBL_LG;
            bound = (bound_shadow > PROBE_CAP) ? PROBE_CAP : bound_shadow;
            mask  = (32'd1 << lg) - 32'd1;
            slot  = mix32(rq.key) & mask;
            oc    = OUT_OVERFLOW;
            for (probe = 0; probe < bound; probe++) begin
                // The reserved key looks like an empty slot, so it "lands" without changing it.
                if (stored_keys[slot] == EMPTY_KEY) begin
                    stored_keys[slot] = rq.key;
                    oc = OUT_INSERTED;
                    break;
                end
                if (stored_keys[slot] == rq.key) begin
                    oc = OUT_DUPLICATE;
                    break;
                end
                slot = (slot + 32'd1) & mask;
            end
            r.outcome = oc;
            r.used    = USED_W'(probe + 1);
            if (r.used > peak_used) peak_used = r.used;
            case (oc)
                OUT_INSERTED:  ins_tot = sat_inc(ins_tot);
                OUT_DUPLICATE: dup_tot = sat_inc(dup_tot);
                default:       ovf_tot = sat_inc(ovf_tot);
            endcase
        end
        r.ins  = ins_tot;
        r.dup  = dup_tot;
        r.ovf  = ovf_tot;
        r.peak = peak_used;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    initial clear_set();

    // Input driver: offers queued items, holding each until its transaction completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // Hold the current item.
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending[0].cmd;
            s_tdata  <= pending[0].key;
            gap_left <= idle_len();
            void'(pending.pop_front());
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off so the core backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!held_off && in_count >= HOLD_AT) begin
            m_tready   <= 1'b0;
            stall_left <= HOLD_LEN;
            held_off   <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= idle_len();
        end
    end

    // Monitor: predicts on each input transaction and checks each result transaction.
    always @(posedge aclk) begin
        req_t rq;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result transaction with no expected result");
            end else begin
                want = result_q.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(m_tuser));
                check_field("probes_used", 32'(want.used), 32'(m_tdata[10:0]));
                check_field("inserted_total", want.ins, m_tdata[42:11]);
                check_field("duplicate_total", want.dup, m_tdata[74:43]);
                check_field("overflow_total", want.ovf, m_tdata[106:75]);
                check_field("max_probe_seen", 32'(want.peak), 32'(m_tdata[117:107]));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            rq.cmd = cmd_t'(s_tuser);
            rq.key = s_tdata;
            dedup_predict(rq, want);
            result_q.insert(result_q.size(), want);
            in_count <= in_count + 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending.size() != 0 || result_q.size() != 0 || s_tvalid);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == CFG_CAPACITY_LOG2) cap_shadow = val[3:0];
        else bound_shadow = val;
    endtask

    task automatic push_req(input cmd_t cmd, input logic [31:0] key);
        req_t rq;
        rq.cmd = cmd;
        rq.key = key;
        pending.insert(pending.size(), rq);
    endtask

    // Keys are drawn mostly from a small pool so that duplicates and full tables occur.
    task automatic run_phase(input logic [3:0] cap, input logic [CFG_W-1:0] bound,
                             input int n, input int pool_n, input bit calm);
        logic [31:0] pool [$];
        logic [31:0] k;
        int unsigned pick;
        wait_idle();
        write_reg(CFG_CAPACITY_LOG2, CFG_W'(cap));
        write_reg(CFG_MAX_PROBE, bound);
        @(negedge aclk);
        quiet = calm;
        for (int i = 0; i < pool_n; i++) begin
            k = $urandom;
            pool.insert(pool.size(), (k == EMPTY_KEY) ? 32'hffff_fffe : k);
        end
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom;
            if (pick < 3) push_req(CMD_CLEAR, k);
            else if (pick < 4) push_req(CMD_INSERT, EMPTY_KEY);
            else if (pick < 88) push_req(CMD_INSERT, pool[$urandom_range(0, pool_n - 1)]);
            else push_req(CMD_INSERT, k);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings.
        push_req(CMD_INSERT, 32'h0000_0000);
        push_req(CMD_INSERT, 32'h0000_0000);
        push_req(CMD_INSERT, 32'hffff_fffe);
        push_req(CMD_INSERT, EMPTY_KEY);
        push_req(CMD_INSERT, EMPTY_KEY);
        push_req(CMD_INSERT, 32'hffff_fffe);
        push_req(CMD_INSERT, 32'h0000_0001);
        push_req(CMD_INSERT, 32'h8000_0000);
        push_req(CMD_INSERT, 32'h7fff_ffff);
        push_req(CMD_INSERT, 32'h5555_5555);
        push_req(CMD_INSERT, 32'haaaa_aaaa);
        push_req(CMD_CLEAR,  EMPTY_KEY);
        push_req(CMD_INSERT, 32'h0000_0000);
        push_req(CMD_INSERT, 32'h0000_0000);
        push_req(CMD_CLEAR,  32'h0000_0000);
        push_req(CMD_INSERT, 32'h1234_5678);

        // Table contents carry over between phases, so capacity changes hit a filled table.
        run_phase(4'd0,  11'd0,    40,   4, 1'b0);
        run_phase(4'd1,  11'd1,    60,   4, 1'b0);
        run_phase(4'd3,  11'd4,    100, 12, 1'b0);
        run_phase(4'd4,  11'd2047, 80,  18, 1'b0);
        run_phase(4'd15, 11'd1024, 150, 800, 1'b1);
        run_phase(4'd6,  11'd8,    150, 100, 1'b0);
        run_phase(4'd10, 11'd1,    80,  300, 1'b0);
        run_phase(4'd2,  11'd1024, 60,   6, 1'b0);
        run_phase(4'd8,  11'd64,   180, 400, 1'b0);

        wait_idle();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
